// ===== hw/rtl/per_class_overlap_suppression_assert.svh =====
// Assertion macros shared by the overlap suppression RTL.
// Depends on nothing; included by the files that check their own logic.
`ifndef PER_CLASS_OVERLAP_SUPPRESSION_ASSERT_SVH
`define PER_CLASS_OVERLAP_SUPPRESSION_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCOS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PCOS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/pcos_pkg.sv =====
// Shared constants and types of the per-class overlap suppression block.
// Depends on nothing; used by the interfaces, the cell and the top level.
package pcos_pkg;

    localparam int MAX_KEPT_DEF   = 64;
    localparam int COORD_BITS_DEF = 16;
    localparam int LABEL_W        = 8;
    localparam int TOTAL_W        = 7;

    // Control part of the candidate token that walks the cell chain.
    typedef struct packed {
        logic valid;
        logic hit;
    } pcos_tok_t;

endpackage

// ===== hw/rtl/pcos_in_if.sv =====
// Proposal channel: valid/ready handshake with the corner and label payload.
// Depends on pcos_pkg for the default coordinate width and label width.
interface pcos_in_if #(
    parameter int COORD_BITS = pcos_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         frame_start;
    logic signed [COORD_BITS-1:0] corner1_x;
    logic signed [COORD_BITS-1:0] corner1_y;
    logic signed [COORD_BITS-1:0] corner2_x;
    logic signed [COORD_BITS-1:0] corner2_y;
    logic signed [COORD_BITS-1:0] corner3_x;
    logic signed [COORD_BITS-1:0] corner3_y;
    logic signed [COORD_BITS-1:0] corner4_x;
    logic signed [COORD_BITS-1:0] corner4_y;
    logic [pcos_pkg::LABEL_W-1:0] class_label;

    modport source (
        output valid, frame_start, corner1_x, corner1_y, corner2_x, corner2_y,
               corner3_x, corner3_y, corner4_x, corner4_y, class_label,
        input  ready
    );
    modport sink (
        input  valid, frame_start, corner1_x, corner1_y, corner2_x, corner2_y,
               corner3_x, corner3_y, corner4_x, corner4_y, class_label,
        output ready
    );
endinterface

// ===== hw/rtl/pcos_out_if.sv =====
// Result channel: valid/ready handshake with keep, kept_total and overflow.
// Depends on pcos_pkg for the width of the kept total.
interface pcos_out_if;
    logic                         valid;
    logic                         ready;
    logic                         keep;
    logic [pcos_pkg::TOTAL_W-1:0] kept_total;
    logic                         overflow;

    modport source (
        output valid, keep, kept_total, overflow,
        input  ready
    );
    modport sink (
        input  valid, keep, kept_total, overflow,
        output ready
    );
endinterface

// ===== hw/rtl/per_class_overlap_suppression.sv =====
//  channel   | dir | handshake      | payload
//  proposal  | in  | valid / ready  | frame_start, corner1..4 x/y, class_label
//  result    | out | valid / ready  | keep, kept_total, overflow
//
// One proposal at a time: it passes the entry register, every chain cell's register,
// the verdict hold register and, once the result slot is free, the output register.
// The next proposal is taken in the cycle after the previous result is loaded.
// Reset clears control state and fill count; stored boxes are never read before written.
// A stalled result holds in the output register while the next proposal walks
// the chain; that proposal's table update waits until the result slot frees.
module per_class_overlap_suppression #(
    parameter int MAX_KEPT   = pcos_pkg::MAX_KEPT_DEF,
    parameter int COORD_BITS = pcos_pkg::COORD_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    pcos_in_if.sink    proposal,
    pcos_out_if.source result
);
    import pcos_pkg::*;

    `include "per_class_overlap_suppression_assert.svh"

    localparam int CW = $clog2(MAX_KEPT + 1);
    localparam int IW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CB = COORD_BITS;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_COMMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0]      count_reg, count_next;
    pcos_tok_t          entry_tok_reg, entry_tok_next;
    logic [4*CB-1:0]    entry_box_reg;
    logic [LABEL_W-1:0] entry_label_reg;

    logic               hold_hit_reg;
    logic [4*CB-1:0]    hold_box_reg;
    logic [LABEL_W-1:0] hold_label_reg;

    logic               out_valid_reg, out_valid_next;
    logic               keep_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic               ovf_reg;

    logic               accept;
    logic               out_free;
    logic               commit;
    logic               keep_now;
    logic               full;
    logic               wr_en;
    logic [4*CB-1:0]    cand_box;

    pcos_tok_t          tok   [0:MAX_KEPT];
    logic [4*CB-1:0]    boxes [0:MAX_KEPT];
    logic [LABEL_W-1:0] labels[0:MAX_KEPT];

    // Axis-aligned bounding box of the four corners.
    logic signed [CB-1:0] xa, xb, xc, xd, ya, yb, yc, yd;
    logic signed [CB-1:0] xn01, xn23, xx01, xx23, yn01, yn23, yx01, yx23;
    logic signed [CB-1:0] xmin, xmax, ymin, ymax;

    always_comb
    begin
        xa = proposal.corner1_x;
        xb = proposal.corner2_x;
        xc = proposal.corner3_x;
        xd = proposal.corner4_x;
        ya = proposal.corner1_y;
        yb = proposal.corner2_y;
        yc = proposal.corner3_y;
        yd = proposal.corner4_y;
        xn01 = (xa < xb) ? xa : xb;
        xn23 = (xc < xd) ? xc : xd;
        xx01 = (xa > xb) ? xa : xb;
        xx23 = (xc > xd) ? xc : xd;
        yn01 = (ya < yb) ? ya : yb;
        yn23 = (yc < yd) ? yc : yd;
        yx01 = (ya > yb) ? ya : yb;
        yx23 = (yc > yd) ? yc : yd;
        xmin = (xn01 < xn23) ? xn01 : xn23;
        xmax = (xx01 > xx23) ? xx01 : xx23;
        ymin = (yn01 < yn23) ? yn01 : yn23;
        ymax = (yx01 > yx23) ? yx01 : yx23;
        cand_box = {xmin, ymin, xmax, ymax};
    end

    assign proposal.ready = (state_reg == S_IDLE);
    assign accept         = proposal.valid && proposal.ready;

    assign out_free = !out_valid_reg || result.ready;
    assign commit   = (state_reg == S_COMMIT) && out_free;
    assign full     = (count_reg == CW'(MAX_KEPT));
    assign keep_now = !hold_hit_reg;
    assign wr_en    = commit && keep_now && !full;

    always_comb
    begin
        entry_tok_next.valid = accept;
        entry_tok_next.hit   = 1'b0;
    end

    assign tok[0]    = entry_tok_reg;
    assign boxes[0]  = entry_box_reg;
    assign labels[0] = entry_label_reg;

    for (genvar i = 0; i < MAX_KEPT; i++)
    begin : g_cell
        pcos_cell #(
            .MAX_KEPT   (MAX_KEPT),
            .COORD_BITS (COORD_BITS),
            .INDEX      (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .count     (count_reg),
            .tok_in    (tok[i]),
            .box_in    (boxes[i]),
            .label_in  (labels[i]),
            .tok_out   (tok[i+1]),
            .box_out   (boxes[i+1]),
            .label_out (labels[i+1]),
            .wr_en     (wr_en),
            .wr_idx    (count_reg[IW-1:0]),
            .wr_box    (hold_box_reg),
            .wr_label  (hold_label_reg)
        );
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (tok[MAX_KEPT].valid)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // A frame start empties the table before its proposal meets any cell.
    always_comb
    begin
        count_next = count_reg;
        if (accept && proposal.frame_start)
        begin
            count_next = '0;
        end
        else if (wr_en)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            entry_tok_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            entry_tok_reg <= entry_tok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_box_reg   <= cand_box;
            entry_label_reg <= proposal.class_label;
        end
        if ((state_reg == S_SCAN) && tok[MAX_KEPT].valid)
        begin
            hold_hit_reg   <= tok[MAX_KEPT].hit;
            hold_box_reg   <= boxes[MAX_KEPT];
            hold_label_reg <= labels[MAX_KEPT];
        end
        if (commit)
        begin
            keep_reg  <= keep_now;
            ovf_reg   <= keep_now && full;
            total_reg <= TOTAL_W'(count_next);
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.keep       = keep_reg;
    assign result.kept_total = total_reg;
    assign result.overflow   = ovf_reg;

    logic [MAX_KEPT:0] chain_valid;
    for (genvar j = 0; j <= MAX_KEPT; j++)
    begin : g_chain_valid
        assign chain_valid[j] = tok[j].valid;
    end

    // Only one candidate may be in the chain at any time.
    `PCOS_ASSERT_SAME(a_one_token, clk, rst_n, 1'b1, $onehot0(chain_valid), "two items in chain")
    // The fill count never passes the table size.
    `PCOS_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(MAX_KEPT), "count too large")
    // An overflow is only ever reported for a kept proposal.
    `PCOS_ASSERT_SAME(a_ovf_keep, clk, rst_n, result.valid, !result.overflow || result.keep, "overflow without keep")
    // Storing a box grows the table by exactly one entry.
    `PCOS_ASSERT_NEXT(a_store_inc, clk, rst_n, wr_en, count_reg == $past(count_reg) + CW'(1), "count not bumped")

endmodule

// ===== hw/rtl/pcos_cell.sv =====
// One cell of the kept-box chain: stores one box and label, tests the passing
// candidate against it and hands the candidate on. Depends on pcos_pkg.
module pcos_cell #(
    parameter int MAX_KEPT   = pcos_pkg::MAX_KEPT_DEF,
    parameter int COORD_BITS = pcos_pkg::COORD_BITS_DEF,
    parameter int INDEX      = 0
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic [$clog2(MAX_KEPT+1)-1:0]              count,
    input  pcos_pkg::pcos_tok_t                        tok_in,
    input  logic [4*COORD_BITS-1:0]                    box_in,
    input  logic [pcos_pkg::LABEL_W-1:0]               label_in,
    output pcos_pkg::pcos_tok_t                        tok_out,
    output logic [4*COORD_BITS-1:0]                    box_out,
    output logic [pcos_pkg::LABEL_W-1:0]               label_out,
    input  logic                                       wr_en,
    input  logic [((MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1)-1:0] wr_idx,
    input  logic [4*COORD_BITS-1:0]                    wr_box,
    input  logic [pcos_pkg::LABEL_W-1:0]               wr_label
);
    import pcos_pkg::*;

    localparam int CW = $clog2(MAX_KEPT + 1);
    localparam int IW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CB = COORD_BITS;

    logic [4*CB-1:0]    entry_box_reg;
    logic [LABEL_W-1:0] entry_label_reg;
    pcos_tok_t          tok_reg;
    pcos_tok_t          tok_next;
    logic [4*CB-1:0]    box_reg;
    logic [LABEL_W-1:0] label_reg;

    logic signed [CB-1:0] c_xmin, c_ymin, c_xmax, c_ymax;
    logic signed [CB-1:0] s_xmin, s_ymin, s_xmax, s_ymax;
    logic                 active;
    logic                 ovl_x;
    logic                 ovl_y;
    logic                 hit;

    // Boxes are packed as xmin, ymin, xmax, ymax from the top down.
    assign c_xmin = $signed(box_in[4*CB-1:3*CB]);
    assign c_ymin = $signed(box_in[3*CB-1:2*CB]);
    assign c_xmax = $signed(box_in[2*CB-1:CB]);
    assign c_ymax = $signed(box_in[CB-1:0]);
    assign s_xmin = $signed(entry_box_reg[4*CB-1:3*CB]);
    assign s_ymin = $signed(entry_box_reg[3*CB-1:2*CB]);
    assign s_xmax = $signed(entry_box_reg[2*CB-1:CB]);
    assign s_ymax = $signed(entry_box_reg[CB-1:0]);

    // Only entries below the fill count hold boxes of the current table.
    assign active = (count > CW'(INDEX));

    // min(maxes) > max(mins) is the same as every max beating every min.
    assign ovl_x = (c_xmax > c_xmin) && (c_xmax > s_xmin) &&
                   (s_xmax > c_xmin) && (s_xmax > s_xmin);
    assign ovl_y = (c_ymax > c_ymin) && (c_ymax > s_ymin) &&
                   (s_ymax > c_ymin) && (s_ymax > s_ymin);
    assign hit   = active && (entry_label_reg == label_in) && ovl_x && ovl_y;

    always_comb
    begin
        tok_next.valid = tok_in.valid;
        tok_next.hit   = tok_in.hit || (tok_in.valid && hit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        box_reg   <= box_in;
        label_reg <= label_in;
        if (wr_en && (wr_idx == IW'(INDEX)))
        begin
            entry_box_reg   <= wr_box;
            entry_label_reg <= wr_label;
        end
    end

    assign tok_out   = tok_reg;
    assign box_out   = box_reg;
    assign label_out = label_reg;

endmodule

// ===== sim/per_class_overlap_suppression_tb.sv =====
// Self-checking bench for per_class_overlap_suppression: a short directed table,
// then random frames of proposals checked against an in-bench overlap predictor.
// Depends on pcos_pkg, pcos_in_if, pcos_out_if and the block itself.
module per_class_overlap_suppression_tb;

    import pcos_pkg::*;

    localparam int TABLE_DEPTH  = MAX_KEPT_DEF;
    localparam int COORD_W      = COORD_BITS_DEF;
    localparam int COORD_MIN    = -(1 << (COORD_W - 1));
    localparam int COORD_MAX    = (1 << (COORD_W - 1)) - 1;
    localparam int RANDOM_ITEMS = 700;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 400_000;

    typedef struct packed {
        logic                       frame_start;
        logic [3:0][COORD_W-1:0]    cx;
        logic [3:0][COORD_W-1:0]    cy;
        logic [LABEL_W-1:0]         label;
    } proposal_t;

    typedef struct packed {
        logic               keep;
        logic [TOTAL_W-1:0] total;
        logic               overflow;
    } outcome_t;

    typedef struct packed {
        int xmin;
        int ymin;
        int xmax;
        int ymax;
    } rect_t;

    typedef struct {
        proposal_t p;
        bit        typed;
        outcome_t  want;
    } script_row_t;

    typedef enum int {
        SHAPE_FRESH,
        SHAPE_OVERLAP,
        SHAPE_TOUCH,
        SHAPE_FLAT,
        SHAPE_WILD
    } shape_kind_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    pcos_in_if #(.COORD_BITS(COORD_W)) prop_ch ();
    pcos_out_if                         res_ch ();

    per_class_overlap_suppression #(
        .MAX_KEPT   (TABLE_DEPTH),
        .COORD_BITS (COORD_W)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .proposal (prop_ch),
        .result   (res_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predictor copy of the kept table.
    rect_t               kept_rect [TABLE_DEPTH];
    logic [LABEL_W-1:0]  kept_label [TABLE_DEPTH];
    int                  kept_fill = 0;

    outcome_t    pending [$];
    script_row_t script [$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          cycle_count = 0;
    bit          tx_burst = 1'b0;
    bit          rx_burst = 1'b0;

    task automatic flag(input string msg);
        $display("MISMATCH result %0d: %s", results_seen, msg);
        mismatches++;
    endtask

    function automatic int clip(input int v);
        return (v < COORD_MIN) ? COORD_MIN : ((v > COORD_MAX) ? COORD_MAX : v);
    endfunction

    function automatic outcome_t verdict(input bit k, input int total, input bit ovf);
        outcome_t o;
        o.keep     = k;
        o.total    = TOTAL_W'(total);
        o.overflow = ovf;
        return o;
    endfunction

    function automatic proposal_t quad(input bit fs, input int x1, input int y1,
                                       input int x2, input int y2, input int x3,
                                       input int y3, input int x4, input int y4,
                                       input int lbl);
        proposal_t p;
        p.frame_start = fs;
        p.cx[0] = COORD_W'(x1);
        p.cy[0] = COORD_W'(y1);
        p.cx[1] = COORD_W'(x2);
        p.cy[1] = COORD_W'(y2);
        p.cx[2] = COORD_W'(x3);
        p.cy[2] = COORD_W'(y3);
        p.cx[3] = COORD_W'(x4);
        p.cy[3] = COORD_W'(y4);
        p.label = LABEL_W'(lbl);
        return p;
    endfunction

    task automatic add_row(input proposal_t p, input bit typed, input outcome_t want);
        script_row_t row;
        row.p     = p;
        row.typed = typed;
        row.want  = want;
        script.insert(script.size(), row);
    endtask

    // Works out keep / total / overflow for one accepted proposal and updates
    // the kept table the same way the block does.
    function automatic outcome_t judge_proposal(input proposal_t p);
        rect_t c;
        int    v;
        int    w;
        int    h;
        int    i;
        bit    hit;
        bit    ovf;
        if (p.frame_start)
            kept_fill = 0;
        c.xmin = $signed(p.cx[0]);
        c.xmax = c.xmin;
        c.ymin = $signed(p.cy[0]);
        c.ymax = c.ymin;
        for (i = 1; i < 4; i++)
        begin
            v = $signed(p.cx[i]);
            if (v < c.xmin) c.xmin = v;
            if (v > c.xmax) c.xmax = v;
            v = $signed(p.cy[i]);
            if (v < c.ymin) c.ymin = v;
            if (v > c.ymax) c.ymax = v;
        end
        hit = 1'b0;
        for (i = 0; i < kept_fill; i++)
        begin
            w = ((c.xmax < kept_rect[i].xmax) ? c.xmax : kept_rect[i].xmax)
              - ((c.xmin > kept_rect[i].xmin) ? c.xmin : kept_rect[i].xmin);
            h = ((c.ymax < kept_rect[i].ymax) ? c.ymax : kept_rect[i].ymax)
              - ((c.ymin > kept_rect[i].ymin) ? c.ymin : kept_rect[i].ymin);
            if (kept_label[i] == p.label && w > 0 && h > 0)
                hit = 1'b1;
        end
        ovf = 1'b0;
        if (!hit)
        begin
            if (kept_fill < TABLE_DEPTH)
            begin
                kept_rect[kept_fill]  = c;
                kept_label[kept_fill] = p.label;
                kept_fill++;
            end
            else
                ovf = 1'b1;
        end
        return verdict(!hit, kept_fill, ovf);
    endfunction

    // Scatters the four corners so that their bounding box is exactly r:
    // one corner carries each extreme, the others fall anywhere inside.
    function automatic proposal_t spread_quad(input rect_t r, input int lbl);
        proposal_t p;
        int        lo;
        int        hi;
        int        j;
        p.frame_start = 1'b0;
        p.label = LABEL_W'(lbl);
        for (j = 0; j < 4; j++)
        begin
            p.cx[j] = COORD_W'(r.xmin + int'($urandom_range(0, r.xmax - r.xmin)));
            p.cy[j] = COORD_W'(r.ymin + int'($urandom_range(0, r.ymax - r.ymin)));
        end
        lo = $urandom_range(0, 3);
        hi = (lo + 1 + $urandom_range(0, 2)) % 4;
        p.cx[lo] = COORD_W'(r.xmin);
        p.cx[hi] = COORD_W'(r.xmax);
        lo = $urandom_range(0, 3);
        hi = (lo + 1 + $urandom_range(0, 2)) % 4;
        p.cy[lo] = COORD_W'(r.ymin);
        p.cy[hi] = COORD_W'(r.ymax);
        return p;
    endfunction

    function automatic proposal_t draw_proposal(input shape_kind_t kind, input int slot);
        proposal_t p;
        rect_t     r;
        rect_t     t;
        int        i;
        int        ax;
        int        ay;
        int        w;
        int        h;
        int        lbl;
        int        j;
        if (kind != SHAPE_WILD && kind != SHAPE_FRESH && kept_fill == 0)
            kind = SHAPE_FRESH;
        case (kind)
            SHAPE_FRESH:
            begin
                // Each slot owns its own 256 x 256 cell, so fresh boxes of one
                // frame never overlap one another.
                w = $urandom_range(1, 200);
                h = $urandom_range(1, 200);
                r.xmin = -2048 + (slot % 16) * 256 + int'($urandom_range(0, 255 - w));
                r.ymin = -2048 + ((slot / 16) % 16) * 256 + int'($urandom_range(0, 255 - h));
                r.xmax = r.xmin + w;
                r.ymax = r.ymin + h;
                lbl = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(0, 3);
                p = spread_quad(r, lbl);
            end
            SHAPE_OVERLAP, SHAPE_FLAT:
            begin
                i = $urandom_range(0, kept_fill - 1);
                t = kept_rect[i];
                lbl = ($urandom_range(0, 3) != 0) ? int'(kept_label[i])
                                                  : int'($urandom_range(0, 255));
                ax = t.xmin + ((t.xmax > t.xmin) ? int'($urandom_range(0, t.xmax - t.xmin - 1)) : 0);
                ay = t.ymin + ((t.ymax > t.ymin) ? int'($urandom_range(0, t.ymax - t.ymin - 1)) : 0);
                r.xmin = clip(ax - int'($urandom_range(0, 40)));
                r.xmax = clip(ax + 1 + int'($urandom_range(0, 40)));
                r.ymin = clip(ay - int'($urandom_range(0, 40)));
                r.ymax = clip(ay + 1 + int'($urandom_range(0, 40)));
                if (kind == SHAPE_FLAT)
                begin
                    if ($urandom_range(0, 1) == 0)
                        r.xmax = r.xmin;
                    else
                        r.ymax = r.ymin;
                end
                p = spread_quad(r, lbl);
            end
            SHAPE_TOUCH:
            begin
                i = $urandom_range(0, kept_fill - 1);
                t = kept_rect[i];
                r = t;
                if (t.xmax <= COORD_MAX - 64)
                begin
                    r.xmin = t.xmax;
                    r.xmax = t.xmax + int'($urandom_range(1, 64));
                end
                else
                begin
                    r.xmax = t.xmin;
                    r.xmin = clip(t.xmin - int'($urandom_range(1, 64)));
                end
                p = spread_quad(r, int'(kept_label[i]));
            end
            default:
            begin
                for (j = 0; j < 4; j++)
                begin
                    p.cx[j] = COORD_W'($urandom);
                    p.cy[j] = COORD_W'($urandom);
                end
                p.label = LABEL_W'($urandom_range(0, 255));
                p.frame_start = 1'b0;
            end
        endcase
        return p;
    endfunction

    task automatic put_payload(input proposal_t p);
        prop_ch.frame_start <= p.frame_start;
        prop_ch.corner1_x   <= p.cx[0];
        prop_ch.corner1_y   <= p.cy[0];
        prop_ch.corner2_x   <= p.cx[1];
        prop_ch.corner2_y   <= p.cy[1];
        prop_ch.corner3_x   <= p.cx[2];
        prop_ch.corner3_y   <= p.cy[2];
        prop_ch.corner4_x   <= p.cx[3];
        prop_ch.corner4_y   <= p.cy[3];
        prop_ch.class_label <= p.label;
    endtask

    // Called at a falling edge; returns at the falling edge after the accept.
    task automatic offer(input proposal_t p, input bit typed, input outcome_t want);
        int       gap;
        outcome_t pred;
        gap = tx_burst ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            prop_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        put_payload(p);
        prop_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (!prop_ch.ready);
        pred = judge_proposal(p);
        pending.insert(pending.size(), typed ? want : pred);
        @(negedge clk);
    endtask

    initial
    begin
        proposal_t   p;
        shape_kind_t kind;
        int          sent;
        int          len;
        int          k;
        int          slot;
        int          roll;
        bit          long_frame;

        prop_ch.valid <= 1'b0;
        put_payload('0);

        add_row(quad(1, 0, 0, 256, 0, 256, 256, 0, 256, 0), 1'b1, verdict(1, 1, 0));
        add_row(quad(0, 256, 256, 0, 0, 0, 256, 256, 0, 0), 1'b1, verdict(0, 1, 0));
        add_row(quad(0, 0, 0, 256, 0, 256, 256, 0, 256, 1), 1'b1, verdict(1, 2, 0));
        // Shared edge, zero width, zero height, then a one-unit corner overlap.
        add_row(quad(0, 256, 0, 512, 0, 512, 256, 256, 256, 0), 1'b0, '0);
        add_row(quad(0, 128, 0, 128, 256, 128, 64, 128, 200, 0), 1'b0, '0);
        add_row(quad(0, 0, 100, 500, 100, 30, 100, 90, 100, 0), 1'b0, '0);
        add_row(quad(0, 255, 255, 300, 255, 300, 300, 255, 300, 0), 1'b0, '0);
        // Full coordinate range.
        add_row(quad(0, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                     COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 255), 1'b0, '0);
        add_row(quad(0, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN,
                     COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 255), 1'b0, '0);
        add_row(quad(0, COORD_MIN, COORD_MIN, COORD_MIN + 8, COORD_MIN,
                     COORD_MIN + 8, COORD_MIN + 8, COORD_MIN, COORD_MIN + 8, 255),
                1'b0, '0);
        add_row(quad(0, 100, -50, 150, 0, 100, 50, 50, 0, 2), 1'b0, '0);
        add_row(quad(0, 7, 7, 7, 7, 7, 7, 7, 7, 2), 1'b0, '0);
        add_row(quad(0, 21845, -21846, -21846, 21845, -1, 0, 0, -1, 170), 1'b0, '0);
        add_row(quad(0, -21846, 21845, 21845, -21846, 0, -1, -1, 0, 85), 1'b0, '0);
        // A frame start empties the table before the proposal is judged.
        add_row(quad(1, 10, 10, 20, 10, 20, 20, 10, 20, 0), 1'b1, verdict(1, 1, 0));
        add_row(quad(0, 15, 15, 25, 15, 25, 25, 15, 25, 0), 1'b1, verdict(0, 1, 0));
        add_row(quad(1, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                     COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0),
                1'b1, verdict(1, 1, 0));
        add_row(quad(0, COORD_MAX - 1, COORD_MAX - 1, COORD_MAX, COORD_MAX - 1,
                     COORD_MAX, COORD_MAX, COORD_MAX - 1, COORD_MAX, 0), 1'b0, '0);

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[n])
            offer(script[n].p, script[n].typed, script[n].want);

        // Random frames: mostly short ones, now and then a long one that fills
        // the table and runs into overflow.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            long_frame = ($urandom_range(0, 5) == 0);
            len = long_frame ? $urandom_range(66, 80) : $urandom_range(1, 30);
            tx_burst = ($urandom_range(0, 3) == 0);
            slot = 0;
            for (k = 0; k < len; k++)
            begin
                roll = $urandom_range(0, 99);
                if (long_frame)
                    kind = (roll < 85) ? SHAPE_FRESH : ((roll < 95) ? SHAPE_OVERLAP : SHAPE_WILD);
                else if (roll < 45)
                    kind = SHAPE_FRESH;
                else if (roll < 70)
                    kind = SHAPE_OVERLAP;
                else if (roll < 80)
                    kind = SHAPE_TOUCH;
                else if (roll < 88)
                    kind = SHAPE_FLAT;
                else
                    kind = SHAPE_WILD;
                p = draw_proposal(kind, slot);
                if (kind == SHAPE_FRESH)
                    slot++;
                // Now and then a frame carries on from the previous table.
                p.frame_start = (k == 0) && ($urandom_range(0, 9) != 0);
                offer(p, 1'b0, '0);
                sent++;
            end
        end
        prop_ch.valid <= 1'b0;

        while (pending.size() != 0)
            @(posedge clk);
        repeat (TABLE_DEPTH + 8) @(posedge clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Result side: random back-pressure, with two long hold-offs that let the
    // block fill up and stall its proposal input.
    initial
    begin
        int wait_cycles;
        int taken;
        res_ch.ready <= 1'b0;
        taken = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (taken % 40 == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
            if (taken == 150 || taken == 400)
                wait_cycles = HOLD_CYCLES;
            else
                wait_cycles = rx_burst ? 0 : $urandom_range(0, 5);
            if (wait_cycles != 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (wait_cycles) @(negedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_ch.valid);
            taken++;
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            if (pending.size() == 0)
                flag("result item with no proposal pending");
            else
            begin
                want = pending.pop_front();
                if (res_ch.keep !== want.keep)
                    flag($sformatf("keep got %b want %b", res_ch.keep, want.keep));
                if (res_ch.kept_total !== want.total)
                    flag($sformatf("kept_total got %0d want %0d",
                                   res_ch.kept_total, want.total));
                if (res_ch.overflow !== want.overflow)
                    flag($sformatf("overflow got %b want %b",
                                   res_ch.overflow, want.overflow));
            end
            results_seen++;
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TIMEOUT after %0d cycles, %0d results pending", cycle_count, pending.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
